>>> sv/pdc_pkg.sv
`default_nettype none

package pdc_pkg;

   localparam int unsigned CHANNELS    = 4;
   localparam int unsigned CH_W        = $clog2(CHANNELS);
   localparam int unsigned TIME_W      = 32;
   localparam int unsigned COUNT_W     = 32;
   localparam int unsigned MS_W        = 16;
   localparam int unsigned CSR_INDEX_W = 2;

   localparam logic [MS_W-1:0] MIN_PULSE_RESET   = 16'd15;
   localparam logic [MS_W-1:0] RUN_TIMEOUT_RESET = 16'd1000;
   localparam logic [MS_W-1:0] SETTLE_RESET      = 16'd20000;

   // last valid channel: one code beyond the channels means none seen yet
   localparam logic [CH_W:0] NO_CHANNEL = 3'd4;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MIN_PULSE   = 2'd0,
      CSR_RUN_TIMEOUT = 2'd1,
      CSR_SETTLE      = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      DIR_UNKNOWN  = 2'd0,
      DIR_FORWARD  = 2'd1,
      DIR_BACKWARD = 2'd2
   } direction_type;

   typedef enum logic {
      MODE_TICK = 1'b0,
      MODE_EDGE = 1'b1
   } mode_type;

   typedef struct packed {
      logic [MS_W-1:0] min_pulse_ms;
      logic [MS_W-1:0] run_timeout_ms;
      logic [MS_W-1:0] settle_ms;
   } cfg_type;

   typedef struct packed {
      mode_type        mode;
      logic [CH_W-1:0] channel;
      logic            level;
   } event_type;

   typedef struct packed {
      logic signed [COUNT_W-1:0] pulse_count;
      direction_type             direction;
      logic                      running;
      logic                      count_valid;
   } status_type;

endpackage

`default_nettype wire

>>> sv/pdc_core.sv
`default_nettype none

module pdc_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire pdc_pkg::cfg_type   cfg,
   input  wire logic              ev_fire,
   input  wire pdc_pkg::event_type ev,
   output pdc_pkg::status_type     status
);

   logic [pdc_pkg::TIME_W-1:0]  now_ff, now_in;
   logic [pdc_pkg::TIME_W-1:0]  rise_ff [pdc_pkg::CHANNELS];
   logic [pdc_pkg::CH_W:0]      last_ch_ff, last_ch_in;
   pdc_pkg::direction_type      dir_ff, dir_in;
   logic [pdc_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [pdc_pkg::MS_W-1:0]    run_ff, run_in;
   logic                        was_running_ff, was_running_in;
   logic [pdc_pkg::MS_W-1:0]    settle_ff, settle_in;

   logic [pdc_pkg::TIME_W-1:0]  high_time;
   logic [pdc_pkg::CH_W-1:0]    prev_ch, next_ch;
   logic [pdc_pkg::MS_W-1:0]    run_dec, settle_dec;
   logic                        run_after;
   logic                        rise_we;
   pdc_pkg::direction_type      pulse_dir;

   assign high_time  = now_ff - rise_ff[ev.channel];
   assign prev_ch    = ev.channel - 1'b1;
   assign next_ch    = ev.channel + 1'b1;
   assign run_dec    = (run_ff != '0) ? run_ff - 1'b1 : run_ff;
   assign settle_dec = (settle_ff != '0) ? settle_ff - 1'b1 : settle_ff;
   assign run_after  = (run_dec != '0);
   assign rise_we    = ev_fire && (ev.mode == pdc_pkg::MODE_EDGE) && ev.level;

   always_comb begin
      if (last_ch_ff == {1'b0, prev_ch}) begin
         pulse_dir = pdc_pkg::DIR_FORWARD;
      end else if (last_ch_ff == {1'b0, next_ch}) begin
         pulse_dir = pdc_pkg::DIR_BACKWARD;
      end else begin
         pulse_dir = pdc_pkg::DIR_UNKNOWN;
      end
   end

   always_comb begin
      now_in         = now_ff;
      last_ch_in     = last_ch_ff;
      dir_in         = dir_ff;
      count_in       = count_ff;
      run_in         = run_ff;
      was_running_in = was_running_ff;
      settle_in      = settle_ff;
      if (ev_fire) begin
         if (ev.mode == pdc_pkg::MODE_TICK) begin
            now_in    = now_ff + 1'b1;
            run_in    = run_dec;
            settle_in = settle_dec;
            if (run_after != was_running_ff) begin
               was_running_in = run_after;
               if (run_after) begin
                  count_in  = '0;
                  settle_in = '0;
               end else begin
                  settle_in = cfg.settle_ms;
               end
            end
         end else if (!ev.level &&
                      high_time >= {{(pdc_pkg::TIME_W-pdc_pkg::MS_W){1'b0}},
                                    cfg.min_pulse_ms}) begin
            last_ch_in = {1'b0, ev.channel};
            dir_in     = pulse_dir;
            run_in     = cfg.run_timeout_ms;
            case (pulse_dir)
               pdc_pkg::DIR_FORWARD:  count_in = count_ff + 1'b1;
               pdc_pkg::DIR_BACKWARD: count_in = count_ff - 1'b1;
               default:               count_in = count_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff         <= '0;
         last_ch_ff     <= pdc_pkg::NO_CHANNEL;
         dir_ff         <= pdc_pkg::DIR_UNKNOWN;
         count_ff       <= '0;
         run_ff         <= '0;
         was_running_ff <= 1'b0;
         settle_ff      <= '0;
         for (int i = 0; i < pdc_pkg::CHANNELS; i++) begin
            rise_ff[i] <= '0;
         end
      end else begin
         now_ff         <= now_in;
         last_ch_ff     <= last_ch_in;
         dir_ff         <= dir_in;
         count_ff       <= count_in;
         run_ff         <= run_in;
         was_running_ff <= was_running_in;
         settle_ff      <= settle_in;
         if (rise_we) begin
            rise_ff[ev.channel] <= now_ff;
         end
      end
   end

   assign status.pulse_count = count_ff;
   assign status.direction   = dir_ff;
   assign status.running     = (run_ff != '0);
   assign status.count_valid = (settle_ff == '0);

endmodule

`default_nettype wire

>>> sv/four_phase_pulse_direction_counter.sv
`default_nettype none

// Four-phase pulse direction counter. Each transfer on the req_ channel is a
// one millisecond tick (req_tuser low) or an edge on one phase line
// (req_tuser high, channel and new level in req_tdata). Every item yields
// exactly one transfer on rsp_ carrying the state after that item: the signed
// forward-minus-backward pulse count (wrapping), the direction of the last
// valid pulse, the running flag and the count-valid flag. The block takes one
// item per clock cycle when rsp_ is not stalled. An item's result is offered
// on rsp_ once the input register has loaded at the transfer edge and the
// state update has followed at a later edge when the result slot is free;
// the state registers drive rsp_tdata directly. Settings on csr_ are always
// taken (csr_ready is tied high) and should be written only while the block
// holds no item.

module four_phase_pulse_direction_counter (
   input  wire logic        clock,
   input  wire logic        reset,
   // request stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [1:0] channel, [2] level, [7:3] zero
   input  wire logic        req_tuser,   // [0] mode: 0 tick, 1 edge
   // result stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // [31:0] pulse_count, [33:32] direction,
                                         // [34] running, [35] count_valid, [39:36] zero
   // register write channel
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [pdc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [pdc_pkg::MS_W-1:0]        csr_data
);

   pdc_pkg::cfg_type    cfg_ff, cfg_in;
   logic                in_valid_ff, in_valid_in;
   pdc_pkg::event_type  in_event_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                req_fire, advance, process;
   pdc_pkg::status_type status;

   // Settings: taken every cycle, writes beyond the list are dropped.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (pdc_pkg::csr_index_type'(csr_index))
            pdc_pkg::CSR_MIN_PULSE:   cfg_in.min_pulse_ms   = csr_data;
            pdc_pkg::CSR_RUN_TIMEOUT: cfg_in.run_timeout_ms = csr_data;
            pdc_pkg::CSR_SETTLE:      cfg_in.settle_ms      = csr_data;
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   // The result slot frees when it is empty or its transfer completes now;
   // the input register may then hand its item to the state update.
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign process    = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff && !process;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (process) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_pulse_ms   <= pdc_pkg::MIN_PULSE_RESET;
         cfg_ff.run_timeout_ms <= pdc_pkg::RUN_TIMEOUT_RESET;
         cfg_ff.settle_ms      <= pdc_pkg::SETTLE_RESET;
         in_valid_ff           <= 1'b0;
         rsp_valid_ff          <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture the payload on every transfer; no reset needed.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_event_ff.mode    <= pdc_pkg::mode_type'(req_tuser);
         in_event_ff.channel <= req_tdata[pdc_pkg::CH_W-1:0];
         in_event_ff.level   <= req_tdata[pdc_pkg::CH_W];
      end
   end

   // State update; its registers double as the result register.
   pdc_core u_core (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .ev_fire (process),
      .ev      (in_event_ff),
      .status  (status)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, status.count_valid, status.running,
                        status.direction, status.pulse_count};

   // The state must not move while no item is being processed.
   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !process |=> $stable(status))
      else $error("state changed without an item being processed");

   // A processed item always leaves a result behind.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      process |=> rsp_valid_ff)
      else $error("processed item produced no result");

   // A buffered item is held until the result slot frees.
   a_input_held: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_event_ff)))
      else $error("buffered item lost while result stalled");

endmodule

`default_nettype wire

>>> verif/tb_four_phase_pulse_direction_counter.sv
`default_nettype none

module tb_four_phase_pulse_direction_counter;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 8;

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [7:0]                      req_tdata  = '0;   // [1:0] channel, [2] level, [7:3] zero
   logic                            req_tuser  = 1'b0; // [0] mode: 0 tick, 1 edge
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [39:0]                     rsp_tdata;         // [31:0] pulse_count, [33:32] direction,
                                                       // [34] running, [35] count_valid
   logic                            csr_valid  = 1'b0;
   logic                            csr_ready;
   logic [pdc_pkg::CSR_INDEX_W-1:0] csr_index  = '0;
   logic [pdc_pkg::MS_W-1:0]        csr_data   = '0;

   four_phase_pulse_direction_counter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Shadow copy of the counter: settings and state, updated per transfer
   // ---------------------------------------------------------------------
   pdc_pkg::cfg_type       shadow_cfg;
   logic [31:0]            shadow_now_ms;
   logic [31:0]            shadow_rise_ms [pdc_pkg::CHANNELS];
   logic [pdc_pkg::CH_W:0] shadow_last_ch;
   pdc_pkg::direction_type shadow_dir;
   logic [31:0]            shadow_fwd;
   logic [31:0]            shadow_bwd;
   logic [15:0]            shadow_run_left;
   logic                   shadow_was_running;
   logic [15:0]            shadow_settle_left;

   pdc_pkg::status_type expected_status_q [$];

   int send_idle_pct   = 0;
   int recv_idle_pct   = 0;
   int rsp_hold_req    = 0;
   int rsp_hold_left   = 0;
   int items_sent      = 0;
   int results_checked = 0;
   int mismatch_count  = 0;
   int error_count     = 0;
   int cycle_count     = 0;

   // pulse walk used by the random part
   logic [1:0] walk_ch = 2'd0;
   logic       walk_up = 1'b1;

   // Apply one event to the shadow state and queue the status it must produce.
   task automatic predict_status(input pdc_pkg::mode_type mode, input logic [1:0] ch,
                                 input logic lvl);
      logic [31:0]            high_ms;
      logic [1:0]             prev_fwd;
      logic [1:0]             prev_bwd;
      pdc_pkg::direction_type dir;
      pdc_pkg::status_type    st;
      logic                   running_now;
      prev_fwd = ch - 2'd1;
      prev_bwd = ch + 2'd1;
      if (mode == pdc_pkg::MODE_TICK) begin
         shadow_now_ms = shadow_now_ms + 32'd1;
         if (shadow_run_left != 16'd0) shadow_run_left = shadow_run_left - 16'd1;
         if (shadow_settle_left != 16'd0) shadow_settle_left = shadow_settle_left - 16'd1;
         running_now = (shadow_run_left != 16'd0);
         // only a tick notices a run or stop change
         if (running_now != shadow_was_running) begin
            shadow_was_running = running_now;
            if (running_now) begin
               shadow_fwd         = '0;
               shadow_bwd         = '0;
               shadow_settle_left = '0;
            end else begin
               shadow_settle_left = shadow_cfg.settle_ms;
            end
         end
      end else if (lvl) begin
         shadow_rise_ms[ch] = shadow_now_ms;
      end else begin
         high_ms = shadow_now_ms - shadow_rise_ms[ch];
         if (high_ms >= {16'd0, shadow_cfg.min_pulse_ms}) begin
            if (shadow_last_ch == {1'b0, prev_fwd})      dir = pdc_pkg::DIR_FORWARD;
            else if (shadow_last_ch == {1'b0, prev_bwd}) dir = pdc_pkg::DIR_BACKWARD;
            else                                         dir = pdc_pkg::DIR_UNKNOWN;
            shadow_last_ch = {1'b0, ch};
            shadow_dir     = dir;
            if (dir == pdc_pkg::DIR_FORWARD)       shadow_fwd = shadow_fwd + 32'd1;
            else if (dir == pdc_pkg::DIR_BACKWARD) shadow_bwd = shadow_bwd + 32'd1;
            // an unknown direction still re-arms the run timeout
            shadow_run_left = shadow_cfg.run_timeout_ms;
         end
      end
      st.pulse_count = shadow_fwd - shadow_bwd;
      st.direction   = shadow_dir;
      st.running     = (shadow_run_left != 16'd0);
      st.count_valid = (shadow_settle_left == 16'd0);
      expected_status_q.push_back(st);
   endtask

   // ---------------------------------------------------------------------
   // Request side: one transfer, with random idle cycles ahead of it
   // ---------------------------------------------------------------------
   task automatic send_event(input pdc_pkg::mode_type mode, input logic [1:0] ch,
                             input logic lvl);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {5'd0, lvl, ch};
      // hold the item until the block takes it
      do @(posedge clock); while (!req_tready);
      predict_status(mode, ch, lvl);
      items_sent++;
   endtask

   task automatic send_tick();
      send_event(pdc_pkg::MODE_TICK, 2'($urandom_range(3)), 1'($urandom_range(1)));
   endtask

   // rising edge, high_ms ticks, falling edge on one phase line
   task automatic send_pulse(input logic [1:0] ch, input int high_ms);
      send_event(pdc_pkg::MODE_EDGE, ch, 1'b1);
      repeat (high_ms) send_tick();
      send_event(pdc_pkg::MODE_EDGE, ch, 1'b0);
   endtask

   // Drop valid and wait until every queued status has been checked.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_status_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write all three registers back to back; call only while idle.
   task automatic load_settings(input logic [pdc_pkg::MS_W-1:0] min_pulse,
                                input logic [pdc_pkg::MS_W-1:0] run_timeout,
                                input logic [pdc_pkg::MS_W-1:0] settle);
      pdc_pkg::csr_index_type idx;
      csr_valid <= 1'b1;
      for (int i = 0; i < 3; i++) begin
         idx = pdc_pkg::csr_index_type'(i);
         csr_index <= idx;
         case (idx)
            pdc_pkg::CSR_MIN_PULSE:   csr_data <= min_pulse;
            pdc_pkg::CSR_RUN_TIMEOUT: csr_data <= run_timeout;
            default:                  csr_data <= settle;
         endcase
         do @(posedge clock); while (!csr_ready);
         case (idx)
            pdc_pkg::CSR_MIN_PULSE:   shadow_cfg.min_pulse_ms   = min_pulse;
            pdc_pkg::CSR_RUN_TIMEOUT: shadow_cfg.run_timeout_ms = run_timeout;
            default:                  shadow_cfg.settle_ms      = settle;
         endcase
      end
      csr_valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Response side: random stalls, plus long hold-offs on request
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (rsp_hold_req != 0) begin
         rsp_hold_left = rsp_hold_req;
         rsp_hold_req  = 0;
      end
      if (rsp_hold_left != 0) begin
         rsp_hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Compare each status transfer with the oldest prediction.
   always @(posedge clock) begin : check_status
      pdc_pkg::status_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_checked++;
         if (expected_status_q.size() == 0) begin
            error_count++;
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("ERROR: unexpected status transfer, tdata %h", rsp_tdata);
         end else begin
            want = expected_status_q.pop_front();
            if (rsp_tdata[31:0] !== want.pulse_count || rsp_tdata[33:32] !== want.direction ||
                rsp_tdata[34] !== want.running || rsp_tdata[35] !== want.count_valid) begin
               error_count++;
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("ERROR: status %0d: count %0d/%0d dir %0d/%0d run %b/%b valid %b/%b",
                           results_checked, $signed(want.pulse_count),
                           $signed(rsp_tdata[31:0]), want.direction, rsp_tdata[33:32],
                           want.running, rsp_tdata[34], want.count_valid, rsp_tdata[35]);
            end
         end
      end
   end

   // Watchdog: end the run if it goes on far longer than any correct run.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Test completed with failures");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   task automatic reset_shadow();
      shadow_cfg.min_pulse_ms   = pdc_pkg::MIN_PULSE_RESET;
      shadow_cfg.run_timeout_ms = pdc_pkg::RUN_TIMEOUT_RESET;
      shadow_cfg.settle_ms      = pdc_pkg::SETTLE_RESET;
      shadow_now_ms      = '0;
      for (int i = 0; i < pdc_pkg::CHANNELS; i++) shadow_rise_ms[i] = '0;
      shadow_last_ch     = pdc_pkg::NO_CHANNEL;
      shadow_dir         = pdc_pkg::DIR_UNKNOWN;
      shadow_fwd         = '0;
      shadow_bwd         = '0;
      shadow_run_left    = '0;
      shadow_was_running = 1'b0;
      shadow_settle_left = '0;
   endtask

   // Reset defaults first, then every direction rule under short timers.
   task automatic test_direction_rules();
      // falling edge with no rising edge seen, measured from time zero
      send_event(pdc_pkg::MODE_EDGE, 2'd3, 1'b0);
      wait_idle();
      load_settings(16'd0, 16'd3, 16'd2);
      send_event(pdc_pkg::MODE_EDGE, 2'd0, 1'b0);   // no previous channel: unknown, re-arms
      send_tick();                                  // stop to run: clear counters
      send_pulse(2'd1, 0);                          // forward
      send_pulse(2'd0, 1);                          // backward, count back to zero
      send_event(pdc_pkg::MODE_EDGE, 2'd2, 1'b0);   // opposite channel: unknown
      send_pulse(2'd3, 0);                          // forward
      repeat (5) send_tick();                       // run out, settle, count valid
      wait_idle();
   endtask

   // Register extremes: an unreachable width, a zero timeout, the longest timers.
   task automatic test_register_extremes();
      load_settings(16'hFFFF, 16'd0, 16'hFFFF);
      send_pulse(2'd2, 1);                          // too short, ignored
      wait_idle();
      load_settings(16'd0, 16'd0, 16'hFFFF);
      send_event(pdc_pkg::MODE_EDGE, 2'd0, 1'b0);   // valid, yet the zero timeout keeps it stopped
      send_tick();
      wait_idle();
      load_settings(16'd0, 16'hFFFF, 16'hFFFF);
      send_event(pdc_pkg::MODE_EDGE, 2'd1, 1'b0);
      send_tick();
      wait_idle();
   endtask

   // Mostly well-formed pulses walking round the phases, some tick runs, some noise.
   task automatic random_burst(input int n_items);
      int target;
      int pick;
      int high_max;
      target = items_sent + n_items;
      while (items_sent < target) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            if ($urandom_range(9) == 0) walk_up = ~walk_up;
            if ($urandom_range(19) == 0) walk_ch = 2'($urandom_range(3));
            else                         walk_ch = walk_up ? walk_ch + 2'd1 : walk_ch - 2'd1;
            high_max = (shadow_cfg.min_pulse_ms > 20) ? 20 : shadow_cfg.min_pulse_ms + 3;
            send_pulse(walk_ch, $urandom_range(high_max));
         end else if (pick < 85) begin
            repeat ($urandom_range(1, 40)) send_tick();
         end else begin
            send_event(pdc_pkg::mode_type'($urandom_range(1)), 2'($urandom_range(3)),
                       1'($urandom_range(1)));
         end
      end
   endtask

   // New settings, then two bursts with a full pause between them.
   task automatic test_random_phase(input int send_pct, input int recv_pct,
                                    input logic [pdc_pkg::MS_W-1:0] min_pulse,
                                    input logic [pdc_pkg::MS_W-1:0] run_timeout,
                                    input logic [pdc_pkg::MS_W-1:0] settle,
                                    input int n_items);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      wait_idle();
      load_settings(min_pulse, run_timeout, settle);
      random_burst(n_items / 2);
      wait_idle();
      random_burst(n_items / 2);
   endtask

   // Stall the response side for a long stretch while requests keep coming.
   task automatic test_backpressure();
      send_idle_pct = 0;
      rsp_hold_req  = 200;
      random_burst(60);
   endtask

   initial begin
      reset_shadow();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 34;
      recv_idle_pct = 60;
      test_direction_rules();
      test_register_extremes();
      test_random_phase(34, 60, 16'd2, 16'd12, 16'd25, 160);
      test_backpressure();
      test_random_phase(60, 34, 16'd5, 16'd30, 16'd6, 160);
      test_random_phase(0, 0, 16'd1, 16'd8, 16'd0, 160);
      wait_idle();

      if (expected_status_q.size() != 0) error_count += expected_status_q.size();
      $display("Summary: %0d events sent, %0d status transfers checked, %0d mismatches",
               items_sent, results_checked, mismatch_count);
      $display("Covered: direction rules, register extremes, long stall, three idle mixes");
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

`default_nettype wire
